// ----- hw/rtl/light_tracker_servo_step_assert.svh -----
// Assertion macros shared by the light tracker checker.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef LIGHT_TRACKER_SERVO_STEP_ASSERT_SVH
`define LIGHT_TRACKER_SERVO_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("light tracker check failed");

// Consequent must hold in the cycle after the antecedent.
`define LTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("light tracker check failed");

`endif

// ----- hw/rtl/lts_pkg.sv -----
package lts_pkg;

    // Fixed field widths.
    localparam int FRAC_BITS   = 16;
    localparam int GAIN_W      = 16;
    localparam int LEVEL_W     = 12;
    localparam int STEP_W      = 4;
    localparam int ANGLE_W     = 8;
    localparam int PULSE_US_W  = 15;
    localparam int PULSE_NS_W  = 25;
    localparam int PROD_W      = ANGLE_W + PULSE_US_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration registers and angles.
    localparam logic [GAIN_W-1:0]     GAIN_RESET      = 16'd13107;
    localparam logic [LEVEL_W-1:0]    FLOOR_RESET     = 12'd100;
    localparam logic [LEVEL_W-1:0]    DEAD_ZONE_RESET = 12'd50;
    localparam logic [STEP_W-1:0]     STEP_RESET      = 4'd1;
    localparam logic [PULSE_US_W-1:0] PMIN_RESET      = 15'd500;
    localparam logic [PULSE_US_W-1:0] PMAX_RESET      = 15'd2400;
    localparam logic [ANGLE_W-1:0]    ANGLE_RESET     = 8'd90;

    // Largest pulse the block can report, in nanoseconds.
    localparam int NS_PER_US    = 1000;
    localparam int PULSE_NS_MAX = ((2 ** PULSE_US_W) - 1) * NS_PER_US;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SMOOTH_GAIN  = 3'd0,
        REG_LIGHT_FLOOR  = 3'd1,
        REG_DEAD_ZONE    = 3'd2,
        REG_ANGLE_STEP   = 3'd3,
        REG_PULSE_MIN_US = 3'd4,
        REG_PULSE_MAX_US = 3'd5
    } lts_reg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_COMMIT,
        ST_ANGLE,
        ST_MUL,
        ST_DIV,
        ST_SCALE,
        ST_DONE
    } lts_state_t;

    // Controls for one averaging lane.
    typedef struct packed {
        logic load;
        logic shift;
        logic commit;
    } lts_lane_ctrl_t;

endpackage

// ----- hw/rtl/lts_avg_lane.sv -----
// One exponential-average lane. The gain multiply is bit serial: one gain
// bit is consumed per shift, and the bits that fall off the bottom are
// collected into a sticky bit for the round-up of a falling average.
module lts_avg_lane
    import lts_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lts_lane_ctrl_t         ctrl,
    input  logic [SAMPLE_BITS-1:0] raw,
    input  logic                   gain_bit,
    output logic [SAMPLE_BITS-1:0] level
);

    localparam int LW = SAMPLE_BITS + FRAC_BITS;

    logic [LW-1:0] s_reg;
    logic [LW-1:0] s_next;
    logic [LW-1:0] mag_reg;
    logic [LW-1:0] acc_reg;
    logic          neg_reg;
    logic          sticky_reg;
    logic [LW-1:0] target;
    logic [LW:0]   sum;

    assign target = {raw, {FRAC_BITS{1'b0}}};
    assign level  = s_reg[LW-1:FRAC_BITS];

    // Shift-add step: add the magnitude when the gain bit is set, then drop one bit.
    assign sum = {1'b0, acc_reg} + (gain_bit ? {1'b0, mag_reg} : '0);

    // A falling average moves by the product rounded up, a rising one by it rounded down.
    assign s_next = neg_reg ? (s_reg - (acc_reg + LW'(sticky_reg))) : (s_reg + acc_reg);

    // Average state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_reg <= '0;
        end else if (ctrl.commit) begin
            s_reg <= s_next;
        end
    end

    // Multiplier working registers.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            neg_reg    <= (target < s_reg);
            mag_reg    <= (target < s_reg) ? (s_reg - target) : (target - s_reg);
            acc_reg    <= '0;
            sticky_reg <= 1'b0;
        end else if (ctrl.shift) begin
            acc_reg    <= sum[LW:1];
            sticky_reg <= sticky_reg | sum[0];
        end
    end

endmodule

// ----- hw/rtl/lts_cdiv.sv -----
// Restoring divider by a fixed divisor, one quotient bit per step.
// The dividend enters the quotient register and is shifted out MSB first.
module lts_cdiv #(
    parameter int DIVISOR = 180,
    parameter int W       = 23
) (
    input  logic         aclk,
    input  logic         load,
    input  logic         step,
    input  logic [W-1:0] dividend,
    output logic [W-1:0] quotient
);

    localparam int RW = $clog2(DIVISOR + 1);
    localparam logic [RW:0] DIV_C = (RW + 1)'(DIVISOR);

    logic [RW-1:0] rem_reg;
    logic [W-1:0]  q_reg;
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;

    assign trial    = {rem_reg, q_reg[W-1]};
    assign diff     = trial - DIV_C;
    assign ge       = (trial >= DIV_C);
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= '0;
            q_reg   <= dividend;
        end else if (step) begin
            rem_reg <= ge ? diff[RW-1:0] : trial[RW-1:0];
            q_reg   <= {q_reg[W-2:0], ge};
        end
    end

endmodule

// ----- hw/rtl/light_tracker_servo_step.sv -----
// Light tracker servo step: one result beat per accepted input beat.
// A new input set is accepted only in idle, once the previous result has been loaded
// into the output register; each set runs through the bit-serial gain multiply and
// the bit-serial divide of the pulse mapping, and can stall on the result channel.
// Reset (aresetn, synchronous, active low) restores the register defaults,
// clears the four averages, sets both angles to 90 and empties the output.
module light_tracker_servo_step
    import lts_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int ANGLE_LIMIT = 180
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [LEVEL_W-1:0]    s_light_north,
    input  logic [LEVEL_W-1:0]    s_light_west,
    input  logic [LEVEL_W-1:0]    s_light_south,
    input  logic [LEVEL_W-1:0]    s_light_east,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LEVEL_W-1:0]    m_level_north,
    output logic [LEVEL_W-1:0]    m_level_west,
    output logic [LEVEL_W-1:0]    m_level_south,
    output logic [LEVEL_W-1:0]    m_level_east,
    output logic [ANGLE_W-1:0]    m_angle_horizontal,
    output logic [ANGLE_W-1:0]    m_angle_vertical,
    output logic [PULSE_NS_W-1:0] m_pulse_horizontal_ns,
    output logic [PULSE_NS_W-1:0] m_pulse_vertical_ns
);

    localparam int VW       = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam int CNT_MAX  = (GAIN_W > PROD_W) ? GAIN_W : PROD_W;
    localparam int CNT_W    = $clog2(CNT_MAX);
    localparam int SW       = PROD_W + 2;
    localparam logic [CNT_W-1:0] AVG_LAST = CNT_W'(GAIN_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    // Configuration registers.
    logic [GAIN_W-1:0]     smooth_gain_reg;
    logic [LEVEL_W-1:0]    light_floor_reg;
    logic [LEVEL_W-1:0]    dead_zone_reg;
    logic [STEP_W-1:0]     angle_step_reg;
    logic [PULSE_US_W-1:0] pulse_min_reg;
    logic [PULSE_US_W-1:0] pulse_max_reg;

    // Sequencer.
    lts_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    lts_lane_ctrl_t lane_ctrl;
    logic           div_load;
    logic           div_step;
    logic           angle_en;
    logic           scale_en;
    logic           out_load;
    logic           m_valid_reg, m_valid_next;

    // Datapath.
    logic [GAIN_W-1:0]      gain_sr_reg;
    logic [SAMPLE_BITS-1:0] raw_in [4];
    logic [SAMPLE_BITS-1:0] lane_level [4];
    logic [VW-1:0]          lv [4];
    logic [LEVEL_W-1:0]     level_reg [4];
    logic [ANGLE_W-1:0]     angle_h_reg;
    logic [ANGLE_W-1:0]     angle_v_reg;
    logic                   span_neg_reg;
    logic                   span_neg;
    logic [PULSE_US_W-1:0]  span_mag;
    logic [PROD_W-1:0]      prod_h;
    logic [PROD_W-1:0]      prod_v;
    logic [PROD_W-1:0]      quo_h;
    logic [PROD_W-1:0]      quo_v;
    logic [PULSE_US_W-1:0]  us_h_reg;
    logic [PULSE_US_W-1:0]  us_v_reg;
    logic [PULSE_US_W-1:0]  us_h;
    logic [PULSE_US_W-1:0]  us_v;
    logic [PULSE_NS_W-1:0]  ns_h;
    logic [PULSE_NS_W-1:0]  ns_v;

    // Output registers.
    logic [LEVEL_W-1:0]    out_level_reg [4];
    logic [ANGLE_W-1:0]    out_angle_h_reg;
    logic [ANGLE_W-1:0]    out_angle_v_reg;
    logic [PULSE_NS_W-1:0] out_pulse_h_reg;
    logic [PULSE_NS_W-1:0] out_pulse_v_reg;

    // Moves one angle a step toward the brighter side and clamps it to 0..ANGLE_LIMIT.
    function automatic logic [ANGLE_W-1:0] move_angle(
        input logic [ANGLE_W-1:0] angle,
        input logic [VW-1:0]      pos,
        input logic [VW-1:0]      neg,
        input logic [VW-1:0]      dz,
        input logic [STEP_W-1:0]  stp
    );
        logic                      up;
        logic [VW-1:0]             mag;
        logic signed [ANGLE_W+1:0] t;
        logic signed [ANGLE_W+1:0] st;
        logic signed [ANGLE_W+1:0] lim;
        logic [ANGLE_W-1:0]        res;
        up  = (pos > neg);
        mag = up ? (pos - neg) : (neg - pos);
        t   = $signed({2'b00, angle});
        st  = $signed({{(ANGLE_W + 2 - STEP_W){1'b0}}, stp});
        lim = $signed((ANGLE_W + 2)'(ANGLE_LIMIT));
        if (mag > dz) begin
            t = up ? (t + st) : (t - st);
        end
        if (t < 0) begin
            res = '0;
        end else if (t > lim) begin
            res = ANGLE_W'(ANGLE_LIMIT);
        end else begin
            res = t[ANGLE_W-1:0];
        end
        return res;
    endfunction

    // Pulse in microseconds, from a signed sum saturated at zero.
    function automatic logic [PULSE_US_W-1:0] to_us(
        input logic [PULSE_US_W-1:0] pmin,
        input logic [PROD_W-1:0]     q,
        input logic                  sub
    );
        logic signed [SW-1:0] base;
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] sum;
        base = $signed(SW'(pmin));
        qs   = $signed(SW'(q));
        sum  = sub ? (base - qs) : (base + qs);
        return (sum < 0) ? '0 : sum[PULSE_US_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    // Configuration writes; data beyond a register's width is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_gain_reg <= GAIN_RESET;
            light_floor_reg <= FLOOR_RESET;
            dead_zone_reg   <= DEAD_ZONE_RESET;
            angle_step_reg  <= STEP_RESET;
            pulse_min_reg   <= PMIN_RESET;
            pulse_max_reg   <= PMAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_SMOOTH_GAIN:  smooth_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_LIGHT_FLOOR:  light_floor_reg <= cfg_data[LEVEL_W-1:0];
                REG_DEAD_ZONE:    dead_zone_reg   <= cfg_data[LEVEL_W-1:0];
                REG_ANGLE_STEP:   angle_step_reg  <= cfg_data[STEP_W-1:0];
                REG_PULSE_MIN_US: pulse_min_reg   <= cfg_data[PULSE_US_W-1:0];
                REG_PULSE_MAX_US: pulse_max_reg   <= cfg_data[PULSE_US_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state and step controls.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lane_ctrl  = '0;
        div_load   = 1'b0;
        div_step   = 1'b0;
        angle_en   = 1'b0;
        scale_en   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    lane_ctrl.load = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_AVG;
                end
            end
            ST_AVG: begin
                lane_ctrl.shift = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == AVG_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                lane_ctrl.commit = 1'b1;
                state_next       = ST_ANGLE;
            end
            ST_ANGLE: begin
                angle_en   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                div_load   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                scale_en   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Result beat is held until taken; a new one may replace it on the same edge.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Gain bits are fed to all four lanes, LSB first.
    always_ff @(posedge aclk) begin
        if (lane_ctrl.load) begin
            gain_sr_reg <= smooth_gain_reg;
        end else if (lane_ctrl.shift) begin
            gain_sr_reg <= {1'b0, gain_sr_reg[GAIN_W-1:1]};
        end
    end

    // Only the low SAMPLE_BITS of each reading take part.
    assign raw_in[0] = SAMPLE_BITS'(s_light_north);
    assign raw_in[1] = SAMPLE_BITS'(s_light_west);
    assign raw_in[2] = SAMPLE_BITS'(s_light_south);
    assign raw_in[3] = SAMPLE_BITS'(s_light_east);

    for (genvar i = 0; i < 4; i++) begin : g_lane
        lts_avg_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl),
            .raw      (raw_in[i]),
            .gain_bit (gain_sr_reg[0]),
            .level    (lane_level[i])
        );

        // Integer part raised to the floor.
        assign lv[i] = (VW'(lane_level[i]) < VW'(light_floor_reg)) ?
                       VW'(light_floor_reg) : VW'(lane_level[i]);
    end

    // Angle state: east against west, north against south.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_h_reg <= ANGLE_RESET;
            angle_v_reg <= ANGLE_RESET;
        end else if (angle_en) begin
            angle_h_reg <= move_angle(angle_h_reg, lv[3], lv[1], VW'(dead_zone_reg),
                                      angle_step_reg);
            angle_v_reg <= move_angle(angle_v_reg, lv[0], lv[2], VW'(dead_zone_reg),
                                      angle_step_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (angle_en) begin
            for (int i = 0; i < 4; i++) begin
                level_reg[i] <= lv[i][LEVEL_W-1:0];
            end
        end
    end

    // Pulse mapping: angle times the span magnitude, then a serial divide by ANGLE_LIMIT.
    assign span_neg = (pulse_max_reg < pulse_min_reg);
    assign span_mag = span_neg ? (pulse_min_reg - pulse_max_reg) : (pulse_max_reg - pulse_min_reg);
    assign prod_h   = {{PULSE_US_W{1'b0}}, angle_h_reg} * {{ANGLE_W{1'b0}}, span_mag};
    assign prod_v   = {{PULSE_US_W{1'b0}}, angle_v_reg} * {{ANGLE_W{1'b0}}, span_mag};

    always_ff @(posedge aclk) begin
        if (div_load) begin
            span_neg_reg <= span_neg;
        end
    end

    lts_cdiv #(
        .DIVISOR(ANGLE_LIMIT),
        .W      (PROD_W)
    ) u_div_h (
        .aclk     (aclk),
        .load     (div_load),
        .step     (div_step),
        .dividend (prod_h),
        .quotient (quo_h)
    );

    lts_cdiv #(
        .DIVISOR(ANGLE_LIMIT),
        .W      (PROD_W)
    ) u_div_v (
        .aclk     (aclk),
        .load     (div_load),
        .step     (div_step),
        .dividend (prod_v),
        .quotient (quo_v)
    );

    // Truncation toward zero: the sign is applied to the quotient magnitude.
    assign us_h = to_us(pulse_min_reg, quo_h, span_neg_reg);
    assign us_v = to_us(pulse_min_reg, quo_v, span_neg_reg);

    always_ff @(posedge aclk) begin
        if (scale_en) begin
            us_h_reg <= us_h;
            us_v_reg <= us_v;
        end
    end

    // Times 1000 as 1024 - 16 - 8.
    assign ns_h = (PULSE_NS_W'(us_h_reg) << 10) - (PULSE_NS_W'(us_h_reg) << 4)
                - (PULSE_NS_W'(us_h_reg) << 3);
    assign ns_v = (PULSE_NS_W'(us_v_reg) << 10) - (PULSE_NS_W'(us_v_reg) << 4)
                - (PULSE_NS_W'(us_v_reg) << 3);

    // Output register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int i = 0; i < 4; i++) begin
                out_level_reg[i] <= level_reg[i];
            end
            out_angle_h_reg <= angle_h_reg;
            out_angle_v_reg <= angle_v_reg;
            out_pulse_h_reg <= ns_h;
            out_pulse_v_reg <= ns_v;
        end
    end

    assign m_level_north         = out_level_reg[0];
    assign m_level_west          = out_level_reg[1];
    assign m_level_south         = out_level_reg[2];
    assign m_level_east          = out_level_reg[3];
    assign m_angle_horizontal    = out_angle_h_reg;
    assign m_angle_vertical      = out_angle_v_reg;
    assign m_pulse_horizontal_ns = out_pulse_h_reg;
    assign m_pulse_vertical_ns   = out_pulse_v_reg;

endmodule

// ----- hw/rtl/lts_checker.sv -----
`include "light_tracker_servo_step_assert.svh"

// Port-level checks for the light tracker servo step.
module lts_checker
    import lts_pkg::*;
#(
    parameter int ANGLE_LIMIT = 180
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ANGLE_W-1:0]    m_angle_horizontal,
    input logic [ANGLE_W-1:0]    m_angle_vertical,
    input logic [PULSE_NS_W-1:0] m_pulse_horizontal_ns,
    input logic [PULSE_NS_W-1:0] m_pulse_vertical_ns
);

    // Reported angles stay inside the servo range.
    `LTS_ASSERT_NOW(a_angle_range, m_valid, (m_angle_horizontal <= ANGLE_LIMIT) && (m_angle_vertical <= ANGLE_LIMIT))

    // Pulses never exceed the widest programmable pulse.
    `LTS_ASSERT_NOW(a_pulse_range, m_valid, (m_pulse_horizontal_ns <= PULSE_NS_MAX) && (m_pulse_vertical_ns <= PULSE_NS_MAX))

    // Only one set is in work at a time.
    `LTS_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // A stalled result beat stays valid, and its horizontal angle and vertical pulse hold.
    `LTS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_angle_horizontal) && $stable(m_pulse_vertical_ns))

endmodule

bind light_tracker_servo_step lts_checker #(
    .ANGLE_LIMIT(ANGLE_LIMIT)
) u_lts_checker (.*);
